// ===== sv/ecsc_pkg.sv =====
// ecsc_pkg: types, codes and reset constants for the EV charge session controller.
// Used by ecsc_step and ev_charge_session_controller; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package ecsc_pkg;

  // Field widths
  localparam int unsigned CurW   = 10;
  localparam int unsigned TempW  = 12;
  localparam int unsigned ReqW   = 11;
  localparam int unsigned VehW   = 3;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDatW = 12;

  // Register reset values
  localparam logic [CurW-1:0]         MaxCurrentRst   = 10'd320;
  localparam logic signed [TempW-1:0] OverheatTempRst = 12'sd600;
  localparam logic [CurW-1:0]         FloorCurrentRst = 10'd60;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_START = 2'd1,
    CMD_STOP  = 2'd2,
    CMD_LIMIT = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    CS_READY    = 2'd0,
    CS_CHARGING = 2'd1,
    CS_OVERHEAT = 2'd2
  } charge_e;

  typedef enum logic [1:0] {
    RLY_NONE     = 2'd0,
    RLY_OPEN     = 2'd1,
    RLY_OPEN_NOW = 2'd2,
    RLY_CLOSE    = 2'd3
  } relay_e;

  typedef enum logic [1:0] {
    STS_OK           = 2'd0,
    STS_ALREADY      = 2'd1,
    STS_NOT_PLUGGED  = 2'd2,
    STS_NOT_CHARGING = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    REG_MAX_CURRENT   = 2'd0,
    REG_OVERHEAT_TEMP = 2'd1,
    REG_FLOOR_CURRENT = 2'd2
  } reg_idx_e;

  // Vehicle state codes
  localparam logic [VehW-1:0] VehNone      = 3'd0;
  localparam logic [VehW-1:0] VehConnected = 3'd1;
  localparam logic [VehW-1:0] VehReady     = 3'd2;
  localparam logic [VehW-1:0] VehReadyVent = 3'd3;

  typedef struct packed {
    logic [CurW-1:0]         max_current;
    logic signed [TempW-1:0] overheat_temp;
    logic [CurW-1:0]         floor_current;
  } cfg_t;

  typedef struct packed {
    logic [1:0]              charge;
    logic [VehW-1:0]         vehicle;
    logic [CurW-1:0]         limit;
    logic                    pilot;
  } sess_t;

  typedef struct packed {
    logic [1:0]              cmd;
    logic [VehW-1:0]         vehicle;
    logic signed [TempW-1:0] temperature;
    logic signed [ReqW-1:0]  limit_request;
  } word_t;

  typedef struct packed {
    logic [1:0]              relay;
    logic [1:0]              status;
    logic                    state_changed;
    logic                    vehicle_changed;
  } evt_t;

  function automatic logic plugged(logic [VehW-1:0] vs);
    return (vs == VehConnected) || (vs == VehReady) || (vs == VehReadyVent);
  endfunction

endpackage

`default_nettype wire

// ===== sv/ecsc_step.sv =====
// ecsc_step: combinational decision for one event word against the session state.
// Depends on ecsc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ecsc_step (
  input  ecsc_pkg::cfg_t  cfg_i,
  input  ecsc_pkg::sess_t sess_i,
  input  ecsc_pkg::word_t word_i,
  output ecsc_pkg::sess_t sess_o,
  output ecsc_pkg::evt_t  evt_o
);

  logic [ecsc_pkg::CurW-1:0] lim_clamped;
  logic                      apply;
  logic                      stopped;
  logic [1:0]                rly_last;
  logic                      req_over;

  // Clamp the requested limit to 0 .. max_current
  assign req_over = word_i.limit_request[ecsc_pkg::ReqW-2:0] > cfg_i.max_current;
  always_comb begin
    if (word_i.limit_request[ecsc_pkg::ReqW-1]) begin
      lim_clamped = '0;
    end else if (req_over) begin
      lim_clamped = cfg_i.max_current;
    end else begin
      lim_clamped = word_i.limit_request[ecsc_pkg::CurW-1:0];
    end
  end

  // Event decision, then limit application on the updated state
  always_comb begin
    sess_o   = sess_i;
    evt_o    = '0;
    apply    = 1'b0;
    stopped  = 1'b0;
    rly_last = ecsc_pkg::RLY_NONE;

    unique case (ecsc_pkg::cmd_e'(word_i.cmd))
      ecsc_pkg::CMD_TICK: begin
        if ((word_i.temperature >= cfg_i.overheat_temp) &&
            (sess_i.charge != ecsc_pkg::CS_OVERHEAT)) begin
          stopped = 1'b1;
          if (sess_i.charge == ecsc_pkg::CS_CHARGING) evt_o.state_changed = 1'b1;
          sess_o.charge = ecsc_pkg::CS_OVERHEAT;
        end
        if (word_i.vehicle != sess_i.vehicle) begin
          sess_o.vehicle = word_i.vehicle;
          if (!ecsc_pkg::plugged(word_i.vehicle) &&
              (sess_o.charge == ecsc_pkg::CS_CHARGING)) begin
            stopped             = 1'b1;
            sess_o.charge       = ecsc_pkg::CS_READY;
            evt_o.state_changed = 1'b1;
          end
          apply                 = 1'b1;
          evt_o.vehicle_changed = 1'b1;
        end
      end
      ecsc_pkg::CMD_START: begin
        if (sess_i.charge == ecsc_pkg::CS_CHARGING) begin
          evt_o.status = ecsc_pkg::STS_ALREADY;
        end else if (!ecsc_pkg::plugged(sess_i.vehicle)) begin
          evt_o.status = ecsc_pkg::STS_NOT_PLUGGED;
        end else begin
          sess_o.charge       = ecsc_pkg::CS_CHARGING;
          apply               = 1'b1;
          evt_o.state_changed = 1'b1;
        end
      end
      ecsc_pkg::CMD_STOP: begin
        stopped = 1'b1;
        if (sess_i.charge != ecsc_pkg::CS_CHARGING) begin
          evt_o.status = ecsc_pkg::STS_NOT_CHARGING;
        end else begin
          sess_o.charge       = ecsc_pkg::CS_READY;
          evt_o.state_changed = 1'b1;
        end
      end
      ecsc_pkg::CMD_LIMIT: begin
        if (lim_clamped != sess_i.limit) begin
          sess_o.limit = lim_clamped;
          apply        = 1'b1;
        end
      end
      default: ;
    endcase

    // Advertise or go to standby
    if (apply) begin
      if (ecsc_pkg::plugged(sess_o.vehicle) && (sess_o.limit >= cfg_i.floor_current)) begin
        sess_o.pilot = 1'b1;
        if ((sess_o.charge == ecsc_pkg::CS_CHARGING) &&
            ((sess_o.vehicle == ecsc_pkg::VehReady) ||
             (sess_o.vehicle == ecsc_pkg::VehReadyVent))) begin
          rly_last = ecsc_pkg::RLY_CLOSE;
        end else begin
          rly_last = ecsc_pkg::RLY_OPEN;
        end
      end else begin
        sess_o.pilot = 1'b0;
        rly_last     = ecsc_pkg::RLY_OPEN;
      end
    end

    // Any stop this step wins over the last open or close
    evt_o.relay = stopped ? ecsc_pkg::RLY_OPEN_NOW : rly_last;
  end

endmodule

`default_nettype wire

// ===== sv/ev_charge_session_controller.sv =====
// ev_charge_session_controller: top level with input register, session state and result register.
// Depends on ecsc_pkg and ecsc_step.
//
//  channel | handshake                | payload
//  --------+--------------------------+-------------------------------------------------
//  cfg     | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//  in      | in_valid_i / in_ready_o   | cmd_i, pilot_vehicle_state_i, temperature_i,
//          |                          | limit_request_i
//  out     | out_valid_o / out_ready_i | relay_cmd_o .. vehicle_changed_o
//
// One word per cycle sustained while results are taken; a word lands in the input
// register, and the session state and result register update together when it
// advances to the result stage, which then drives the outputs.
// The input register keeps taking words while a result waits, until both stages
// are full. Reset clears the handshake state, the session state and the
// configuration registers to their reset values. cfg_ready_o is always high.
`timescale 1ns / 1ps
`default_nettype none

module ev_charge_session_controller (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  // configuration
  input  wire logic                                  cfg_valid_i,
  output logic                                       cfg_ready_o,
  input  wire logic [ecsc_pkg::CfgIdxW-1:0]          cfg_index_i,
  input  wire logic [ecsc_pkg::CfgDatW-1:0]          cfg_data_i,
  // event words
  input  wire logic                                  in_valid_i,
  output logic                                       in_ready_o,
  input  wire logic [1:0]                            cmd_i,
  input  wire logic [ecsc_pkg::VehW-1:0]             pilot_vehicle_state_i,
  input  wire logic signed [ecsc_pkg::TempW-1:0]     temperature_i,
  input  wire logic signed [ecsc_pkg::ReqW-1:0]      limit_request_i,
  // results
  output logic                                       out_valid_o,
  input  wire logic                                  out_ready_i,
  output logic [1:0]                                 relay_cmd_o,
  output logic                                       pilot_advertise_o,
  output logic [ecsc_pkg::CurW-1:0]                  limit_now_o,
  output logic [1:0]                                 charge_state_out_o,
  output logic [ecsc_pkg::VehW-1:0]                  vehicle_state_out_o,
  output logic [1:0]                                 status_o,
  output logic                                       state_changed_o,
  output logic                                       vehicle_changed_o
);

  ecsc_pkg::cfg_t  cfg_q;
  ecsc_pkg::sess_t sess_q, sess_d;
  ecsc_pkg::word_t word_q;
  ecsc_pkg::evt_t  evt_d, evt_q;
  logic            in_vld_q, out_vld_q;
  logic            advance;

  // Configuration writes
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_current   <= ecsc_pkg::MaxCurrentRst;
      cfg_q.overheat_temp <= ecsc_pkg::OverheatTempRst;
      cfg_q.floor_current <= ecsc_pkg::FloorCurrentRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        ecsc_pkg::REG_MAX_CURRENT:   cfg_q.max_current   <= cfg_data_i[ecsc_pkg::CurW-1:0];
        ecsc_pkg::REG_OVERHEAT_TEMP: cfg_q.overheat_temp <= $signed(cfg_data_i);
        ecsc_pkg::REG_FLOOR_CURRENT: cfg_q.floor_current <= cfg_data_i[ecsc_pkg::CurW-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline flow: word moves to the result stage when that stage is free or its result is being taken
  assign advance    = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      word_q.cmd           <= cmd_i;
      word_q.vehicle       <= pilot_vehicle_state_i;
      word_q.temperature   <= temperature_i;
      word_q.limit_request <= limit_request_i;
    end
  end

  ecsc_step u_step (
    .cfg_i  (cfg_q),
    .sess_i (sess_q),
    .word_i (word_q),
    .sess_o (sess_d),
    .evt_o  (evt_d)
  );

  // Session state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sess_q.charge  <= ecsc_pkg::CS_READY;
      sess_q.vehicle <= ecsc_pkg::VehNone;
      sess_q.limit   <= ecsc_pkg::MaxCurrentRst;
      sess_q.pilot   <= 1'b0;
    end else if (advance) begin
      sess_q <= sess_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      evt_q <= evt_d;
    end
  end

  assign out_valid_o         = out_vld_q;
  assign relay_cmd_o         = evt_q.relay;
  assign status_o            = evt_q.status;
  assign state_changed_o     = evt_q.state_changed;
  assign vehicle_changed_o   = evt_q.vehicle_changed;
  assign pilot_advertise_o   = sess_q.pilot;
  assign limit_now_o         = sess_q.limit;
  assign charge_state_out_o  = sess_q.charge;
  assign vehicle_state_out_o = sess_q.vehicle;

  // Checks
  a_pilot_needs_vehicle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    sess_q.pilot |-> ecsc_pkg::plugged(sess_q.vehicle))
    else $error("pilot advertising without a connected vehicle");

  a_stop_opens_now : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && evt_q.state_changed && (sess_q.charge != ecsc_pkg::CS_CHARGING))
    |-> (evt_q.relay == ecsc_pkg::RLY_OPEN_NOW))
    else $error("charging ended without immediate relay open");

  a_close_when_charging : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && (evt_q.relay == ecsc_pkg::RLY_CLOSE))
    |-> ((sess_q.charge == ecsc_pkg::CS_CHARGING) && sess_q.pilot))
    else $error("relay closed outside charging");

  a_stall_only_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (in_vld_q && out_vld_q && !out_ready_i))
    else $error("input stalled with room in the pipeline");

endmodule

`default_nettype wire

// ===== tb/charge_result_checker.sv =====
// charge_result_checker: watches the register, event and result channels of the charge
// session controller, predicts every result and compares it. Depends on ecsc_pkg.
`timescale 1ns / 1ps

module charge_result_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // register writes
  input  logic                                cfg_valid_i,
  input  logic                                cfg_ready_i,
  input  logic [ecsc_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [ecsc_pkg::CfgDatW-1:0]        cfg_data_i,
  // event words
  input  logic                                in_valid_i,
  input  logic                                in_ready_i,
  input  logic [1:0]                          cmd_i,
  input  logic [ecsc_pkg::VehW-1:0]           vehicle_i,
  input  logic signed [ecsc_pkg::TempW-1:0]   temperature_i,
  input  logic signed [ecsc_pkg::ReqW-1:0]    limit_request_i,
  // result words
  input  logic                                out_valid_i,
  input  logic                                out_ready_i,
  input  logic [1:0]                          relay_cmd_i,
  input  logic                                pilot_advertise_i,
  input  logic [ecsc_pkg::CurW-1:0]           limit_now_i,
  input  logic [1:0]                          charge_state_i,
  input  logic [ecsc_pkg::VehW-1:0]           vehicle_state_i,
  input  logic [1:0]                          status_i,
  input  logic                                state_changed_i,
  input  logic                                vehicle_changed_i,
  // to the testbench top
  output int                                  mismatches_o,
  output int                                  outstanding_o,
  output int                                  checked_o,
  output int                                  charge_starts_o,
  output int                                  overheat_trips_o
);

  import ecsc_pkg::*;

  localparam int MaxReports = 10;

  typedef struct packed {
    relay_e          relay;
    logic            pilot;
    logic [CurW-1:0] limit;
    charge_e         charge;
    logic [VehW-1:0] vehicle;
    status_e         status;
    logic            state_chg;
    logic            veh_chg;
  } session_result_t;

  // register copy
  logic [CurW-1:0]         max_cur;
  logic signed [TempW-1:0] hot_thr;
  logic [CurW-1:0]         min_cur;

  // session copy
  charge_e                 charge;
  logic [VehW-1:0]         vehicle;
  logic [CurW-1:0]         limit;
  logic                    pilot;

  // per-word scratch
  relay_e                  relay;
  logic                    opened_now;
  logic                    state_evt;

  session_result_t         expected_results[$];
  int                      mismatch_cnt;
  int                      checked_cnt;
  int                      start_cnt;
  int                      trip_cnt;

  function automatic logic vehicle_attached(input logic [VehW-1:0] v);
    return (v == VehConnected) || (v == VehReady) || (v == VehReadyVent);
  endfunction

  // advertise the limit, or fall back to standby
  task automatic refresh_pilot();
    if (vehicle_attached(vehicle) && limit >= min_cur) begin
      pilot = 1'b1;
      if (charge == CS_CHARGING && (vehicle == VehReady || vehicle == VehReadyVent)) begin
        relay = RLY_CLOSE;
      end else begin
        relay = RLY_OPEN;
      end
    end else begin
      relay = RLY_OPEN;
      pilot = 1'b0;
    end
  endtask

  // stop: the relay always opens at once, state only moves out of charging
  task automatic halt_charging(output status_e st);
    relay      = RLY_OPEN_NOW;
    opened_now = 1'b1;
    if (charge != CS_CHARGING) begin
      st = STS_NOT_CHARGING;
    end else begin
      charge    = CS_READY;
      state_evt = 1'b1;
      st        = STS_OK;
    end
  endtask

  // advance the session copy by one event word
  task automatic predict_session_step(input logic [1:0] c, input logic [VehW-1:0] vs,
                                      input logic signed [TempW-1:0] temp,
                                      input logic signed [ReqW-1:0] req,
                                      output session_result_t res);
    status_e         st;
    status_e         dropped;
    logic            veh_evt;
    int              req_val;
    logic [CurW-1:0] clamped;
    st         = STS_OK;
    veh_evt    = 1'b0;
    relay      = RLY_NONE;
    opened_now = 1'b0;
    state_evt  = 1'b0;
    case (cmd_e'(c))
      CMD_TICK: begin
        if (temp >= hot_thr && charge != CS_OVERHEAT) begin
          halt_charging(dropped);
          charge = CS_OVERHEAT;
          trip_cnt++;
        end
        if (vs != vehicle) begin
          vehicle = vs;
          if (!vehicle_attached(vs) && charge == CS_CHARGING) halt_charging(dropped);
          refresh_pilot();
          veh_evt = 1'b1;
        end
      end
      CMD_START: begin
        if (charge == CS_CHARGING) begin
          st = STS_ALREADY;
        end else if (!vehicle_attached(vehicle)) begin
          st = STS_NOT_PLUGGED;
        end else begin
          // overheat is left by a start as well
          charge = CS_CHARGING;
          refresh_pilot();
          state_evt = 1'b1;
          start_cnt++;
        end
      end
      CMD_STOP: begin
        halt_charging(st);
      end
      default: begin
        req_val = int'(req);
        if (req_val < 0) begin
          clamped = '0;
        end else if (req_val > int'(max_cur)) begin
          clamped = max_cur;
        end else begin
          clamped = req_val[CurW-1:0];
        end
        if (clamped != limit) begin
          limit = clamped;
          refresh_pilot();
        end
      end
    endcase
    // any stop this word wins over other relay commands
    if (opened_now) relay = RLY_OPEN_NOW;
    res.relay     = relay;
    res.pilot     = pilot;
    res.limit     = limit;
    res.charge    = charge;
    res.vehicle   = vehicle;
    res.status    = st;
    res.state_chg = state_evt;
    res.veh_chg   = veh_evt;
  endtask

  task automatic note_mismatch(input string what, input session_result_t want,
                               input session_result_t got);
    mismatch_cnt++;
    if (mismatch_cnt <= MaxReports) begin
      $display("[%0t] %s after %0d results", $realtime, what, checked_cnt);
      $display("  expected relay=%0d pilot=%0d limit=%0d charge=%0d vehicle=%0d status=%0d",
               want.relay, want.pilot, want.limit, want.charge, want.vehicle, want.status);
      $display("           state_chg=%0d veh_chg=%0d", want.state_chg, want.veh_chg);
      $display("  actual   relay=%0d pilot=%0d limit=%0d charge=%0d vehicle=%0d status=%0d",
               got.relay, got.pilot, got.limit, got.charge, got.vehicle, got.status);
      $display("           state_chg=%0d veh_chg=%0d", got.state_chg, got.veh_chg);
    end
  endtask

  // sample all three channels at the clock edge
  always @(posedge clk_i or negedge rst_ni) begin : track_words
    session_result_t want;
    session_result_t got;
    if (!rst_ni) begin
      max_cur      = MaxCurrentRst;
      hot_thr      = OverheatTempRst;
      min_cur      = FloorCurrentRst;
      charge       = CS_READY;
      vehicle      = VehNone;
      limit        = MaxCurrentRst;
      pilot        = 1'b0;
      expected_results.delete();
      mismatch_cnt = 0;
      checked_cnt  = 0;
      start_cnt    = 0;
      trip_cnt     = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_MAX_CURRENT:   max_cur = cfg_data_i[CurW-1:0];
          REG_OVERHEAT_TEMP: hot_thr = cfg_data_i;
          REG_FLOOR_CURRENT: min_cur = cfg_data_i[CurW-1:0];
          default:           ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        got.relay     = relay_e'(relay_cmd_i);
        got.pilot     = pilot_advertise_i;
        got.limit     = limit_now_i;
        got.charge    = charge_e'(charge_state_i);
        got.vehicle   = vehicle_state_i;
        got.status    = status_e'(status_i);
        got.state_chg = state_changed_i;
        got.veh_chg   = vehicle_changed_i;
        if (expected_results.size() == 0) begin
          note_mismatch("result with nothing outstanding", '0, got);
        end else begin
          want = expected_results.pop_front();
          // any field differing, X included
          if (got !== want) note_mismatch("result mismatch", want, got);
          checked_cnt++;
        end
      end
      if (in_valid_i && in_ready_i) begin
        predict_session_step(cmd_i, vehicle_i, temperature_i, limit_request_i, want);
        expected_results.push_back(want);
      end
    end
    mismatches_o     <= mismatch_cnt;
    outstanding_o    <= expected_results.size();
    checked_o        <= checked_cnt;
    charge_starts_o  <= start_cnt;
    overheat_trips_o <= trip_cnt;
  end

endmodule

// ===== tb/testbench.sv =====
// testbench: drives register writes and event words into ev_charge_session_controller
// with random idling on both sides; charge_result_checker does the checking.
`timescale 1ns / 1ps

module testbench;

  import ecsc_pkg::*;

  localparam int ClkHalf    = 4;
  localparam int RstCycles  = 9;
  localparam int CycleLimit = 200000;
  localparam int SettleWait = 6;

  localparam logic [CfgIdxW-1:0] UnusedRegIdx = 2'd3;
  localparam logic [VehW-1:0]    VehNoPower   = 3'd4;
  localparam logic [VehW-1:0]    VehError     = 3'd5;
  localparam logic [VehW-1:0]    VehSpare6    = 3'd6;
  localparam logic [VehW-1:0]    VehSpare7    = 3'd7;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                    cfg_valid = 1'b0;
  logic [CfgIdxW-1:0]      cfg_index = '0;
  logic [CfgDatW-1:0]      cfg_data  = '0;
  logic                    in_valid  = 1'b0;
  logic [1:0]              cmd       = '0;
  logic [VehW-1:0]         veh       = '0;
  logic signed [TempW-1:0] temp      = '0;
  logic signed [ReqW-1:0]  req       = '0;
  logic                    out_ready = 1'b0;

  logic                    cfg_ready;
  logic                    in_ready;
  logic                    out_valid;
  logic [1:0]              relay_cmd;
  logic                    pilot_adv;
  logic [CurW-1:0]         limit_now;
  logic [1:0]              charge_state;
  logic [VehW-1:0]         vehicle_state;
  logic [1:0]              status;
  logic                    state_changed;
  logic                    vehicle_changed;

  int mismatches;
  int outstanding;
  int checked;
  int charge_starts;
  int overheat_trips;

  int              tx_idle_pct = 27;
  int              rx_idle_pct = 82;
  logic            rx_hold     = 1'b0;
  int              cycle_count = 0;
  int              words_sent  = 0;
  int              settings_used = 0;
  int              cur_max = 320;
  int              cur_thr = 600;
  int              cur_min = 60;
  logic [VehW-1:0] veh_drive = '0;

  always #(ClkHalf) clk_i = ~clk_i;

  ev_charge_session_controller u_dut (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cfg_valid_i           (cfg_valid),
    .cfg_ready_o           (cfg_ready),
    .cfg_index_i           (cfg_index),
    .cfg_data_i            (cfg_data),
    .in_valid_i            (in_valid),
    .in_ready_o            (in_ready),
    .cmd_i                 (cmd),
    .pilot_vehicle_state_i (veh),
    .temperature_i         (temp),
    .limit_request_i       (req),
    .out_valid_o           (out_valid),
    .out_ready_i           (out_ready),
    .relay_cmd_o           (relay_cmd),
    .pilot_advertise_o     (pilot_adv),
    .limit_now_o           (limit_now),
    .charge_state_out_o    (charge_state),
    .vehicle_state_out_o   (vehicle_state),
    .status_o              (status),
    .state_changed_o       (state_changed),
    .vehicle_changed_o     (vehicle_changed)
  );

  charge_result_checker u_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_i       (cfg_ready),
    .cfg_index_i       (cfg_index),
    .cfg_data_i        (cfg_data),
    .in_valid_i        (in_valid),
    .in_ready_i        (in_ready),
    .cmd_i             (cmd),
    .vehicle_i         (veh),
    .temperature_i     (temp),
    .limit_request_i   (req),
    .out_valid_i       (out_valid),
    .out_ready_i       (out_ready),
    .relay_cmd_i       (relay_cmd),
    .pilot_advertise_i (pilot_adv),
    .limit_now_i       (limit_now),
    .charge_state_i    (charge_state),
    .vehicle_state_i   (vehicle_state),
    .status_i          (status),
    .state_changed_i   (state_changed),
    .vehicle_changed_i (vehicle_changed),
    .mismatches_o      (mismatches),
    .outstanding_o     (outstanding),
    .checked_o         (checked),
    .charge_starts_o   (charge_starts),
    .overheat_trips_o  (overheat_trips)
  );

  // result side: random back-pressure, or a forced hold-off
  always @(posedge clk_i) begin
    out_ready <= !rx_hold && ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Timed out after %0d cycles with %0d results outstanding",
               cycle_count, outstanding);
      $display("FAILURE");
      $finish;
    end
  end

  // offer one event word, with an optional random gap first
  task automatic send_word(input logic [1:0] c, input logic [VehW-1:0] v,
                           input logic signed [TempW-1:0] t,
                           input logic signed [ReqW-1:0] r);
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < tx_idle_pct);
    end
    in_valid <= 1'b1;
    cmd      <= c;
    veh      <= v;
    temp     <= t;
    req      <= r;
    do @(posedge clk_i); while (!in_ready);
    words_sent++;
  endtask

  task automatic put_register(input logic [CfgIdxW-1:0] idx, input logic [CfgDatW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk_i); while (!cfg_ready);
  endtask

  // all three registers, plus a write to the unused index that must change nothing
  task automatic write_settings(input int max_a, input int thr, input int min_a);
    put_register(REG_MAX_CURRENT, max_a[CfgDatW-1:0]);
    put_register(REG_OVERHEAT_TEMP, thr[CfgDatW-1:0]);
    put_register(REG_FLOOR_CURRENT, min_a[CfgDatW-1:0]);
    put_register(UnusedRegIdx, CfgDatW'($urandom));
    cfg_valid <= 1'b0;
    cur_max = max_a;
    cur_thr = thr;
    cur_min = min_a;
    settings_used++;
  endtask

  // wait until every result is back and the pipeline has settled
  task automatic drain();
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (SettleWait) @(posedge clk_i);
  endtask

  // mostly plausible sessions: a sticky vehicle state, temperatures under or at/over the
  // threshold, requests in range or near the floor; the rest is full-range noise
  task automatic random_word();
    int              pick;
    int              sub;
    int              t;
    int              r;
    logic [1:0]      c;
    logic [VehW-1:0] v;
    pick = $urandom_range(0, 99);
    sub  = $urandom_range(0, 99);
    v    = VehW'($urandom);
    t    = int'($urandom_range(0, 4095)) - 2048;
    r    = int'($urandom_range(0, 2047)) - 1024;
    if (pick < 40) begin
      c = CMD_TICK;
      if ($urandom_range(0, 3) == 0) begin
        if ($urandom_range(0, 9) < 7) veh_drive = VehW'($urandom_range(1, 3));
        else veh_drive = VehW'($urandom_range(0, 7));
      end
      v = veh_drive;
      if (sub < 85) t = cur_thr - 1 - int'($urandom_range(0, 600));
      else if (sub < 93) t = cur_thr + int'($urandom_range(0, 200));
      if (t < -2048) t = -2048;
      if (t > 2047) t = 2047;
    end else if (pick < 62) begin
      c = CMD_START;
    end else if (pick < 77) begin
      c = CMD_STOP;
    end else begin
      c = CMD_LIMIT;
      if (sub < 70) r = int'($urandom_range(0, cur_max));
      else if (sub < 85) r = cur_min + int'($urandom_range(0, 4)) - 2;
      if (r < -1024) r = -1024;
      if (r > 1023) r = 1023;
    end
    send_word(c, v, t[TempW-1:0], r[ReqW-1:0]);
  endtask

  // stimulus and verdict
  initial begin
    int n_words;
    int max_a;
    int thr;
    int min_a;

    repeat (RstCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part, reset register values first
    send_word(CMD_START, VehReady, TempW'($urandom), ReqW'($urandom)); // nothing plugged in
    send_word(CMD_STOP, VehW'($urandom), TempW'($urandom), ReqW'($urandom)); // not charging
    send_word(CMD_LIMIT, VehW'($urandom), TempW'($urandom), 11'sd0);
    send_word(CMD_TICK, VehReady, 12'h800, ReqW'($urandom)); // coldest sample, limit under min
    send_word(CMD_LIMIT, VehW'($urandom), TempW'($urandom), 11'sd1023); // clamped to max
    send_word(CMD_START, VehW'($urandom), TempW'($urandom), ReqW'($urandom));
    send_word(CMD_START, VehW'($urandom), TempW'($urandom), ReqW'($urandom)); // already on
    send_word(CMD_LIMIT, VehW'($urandom), TempW'($urandom), 11'h400); // most negative request
    send_word(CMD_LIMIT, VehW'($urandom), TempW'($urandom), 11'sd60); // exactly the floor
    send_word(CMD_TICK, VehReadyVent, 12'sd599, ReqW'($urandom));
    send_word(CMD_TICK, VehReadyVent, 12'sd600, ReqW'($urandom));   // threshold reached
    send_word(CMD_TICK, VehReadyVent, 12'sd2047, ReqW'($urandom));  // already latched
    send_word(CMD_STOP, VehW'($urandom), TempW'($urandom), ReqW'($urandom)); // in overheat
    send_word(CMD_START, VehW'($urandom), TempW'($urandom), ReqW'($urandom)); // out of it
    send_word(CMD_TICK, VehSpare6, 12'sd1500, ReqW'($urandom));     // trip and unplug together
    send_word(CMD_TICK, VehSpare7, -12'sd400, ReqW'($urandom));
    send_word(CMD_TICK, VehConnected, 12'sd0, ReqW'($urandom));
    send_word(CMD_START, VehW'($urandom), TempW'($urandom), ReqW'($urandom)); // not ready
    send_word(CMD_TICK, VehNoPower, 12'sd0, ReqW'($urandom));       // unplug while charging
    send_word(CMD_TICK, VehError, 12'sd0, ReqW'($urandom));
    send_word(CMD_TICK, VehNone, 12'sd0, ReqW'($urandom));
    in_valid <= 1'b0;
    drain();

    // a new max_current must leave the held limit alone
    write_settings(800, 600, 60);
    send_word(CMD_TICK, VehReady, 12'sd0, ReqW'($urandom));
    send_word(CMD_LIMIT, VehW'($urandom), TempW'($urandom), 11'sd801);
    send_word(CMD_START, VehW'($urandom), TempW'($urandom), ReqW'($urandom));
    send_word(CMD_STOP, VehW'($urandom), TempW'($urandom), ReqW'($urandom));
    in_valid <= 1'b0;
    drain();

    // random phases: slow receiver, slow sender, then no idling under two settings
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          max_a = 800;  thr = 1500; min_a = 0;   n_words = 375;
          tx_idle_pct = 27; rx_idle_pct <= 82;
        end
        1: begin
          max_a = 0;    thr = -400; min_a = 0;   n_words = 375;
          tx_idle_pct = 82; rx_idle_pct <= 27;
        end
        2: begin
          max_a = 320;  thr = 600;  min_a = 60;  n_words = 190;
          tx_idle_pct = 0;  rx_idle_pct <= 0;
        end
        default: begin
          max_a = 1023; thr = 2047; min_a = 800; n_words = 190;
          tx_idle_pct = 0;  rx_idle_pct <= 0;
        end
      endcase
      write_settings(max_a, thr, min_a);
      if (ph == 2) begin
        // long hold-off on the result side while words keep coming
        fork
          begin
            repeat (50) @(posedge clk_i);
            rx_hold <= 1'b1;
            repeat (80) @(posedge clk_i);
            rx_hold <= 1'b0;
          end
        join_none
      end
      repeat (n_words) random_word();
      in_valid <= 1'b0;
      drain();
    end

    $display("Sent %0d event words under %0d register settings; %0d results compared.",
             words_sent, settings_used, checked);
    $display("Charging was entered %0d times and overheat tripped %0d times.",
             charge_starts, overheat_trips);
    if (mismatches == 0 && outstanding == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
